// ===== sv/b2da_pkg.sv =====
// Shared types and constants of the binary to decimal ASCII converter.
package b2da_pkg;

  localparam int WORD_W     = 32;
  localparam int DIGIT_W    = 4;
  localparam int NUM_DIGITS = 10;
  localparam int CNT_W      = 5;

  localparam logic [7:0] ASCII_ZERO  = 8'd48;
  localparam logic [7:0] ASCII_MINUS = 8'd45;

  typedef logic [DIGIT_W-1:0] digit_t;

  typedef struct packed {
    logic clear;
    logic shift_bit;
    logic shift_digit;
  } cell_ctrl_t;

endpackage

// ===== sv/b2da_cell.sv =====
// One decimal digit cell of the shift-and-add-three chain.
module b2da_cell (
  input  logic                clk,
  input  b2da_pkg::cell_ctrl_t ctrl,
  input  logic                bit_in,
  input  b2da_pkg::digit_t    digit_in,
  output logic                bit_out,
  output b2da_pkg::digit_t    digit
);
  import b2da_pkg::*;

  digit_t adjusted;
  digit_t digit_next;

  always_comb begin
    adjusted = (digit >= 4'd5) ? digit + 4'd3 : digit;
    bit_out  = adjusted[DIGIT_W-1];
    digit_next = digit;
    if (ctrl.clear) begin
      digit_next = '0;
    end else if (ctrl.shift_bit) begin
      digit_next = {adjusted[DIGIT_W-2:0], bit_in};
    end else if (ctrl.shift_digit) begin
      digit_next = digit_in;
    end
  end

  always_ff @(posedge clk) begin
    digit <= digit_next;
  end

endmodule

// ===== sv/binary_to_decimal_ascii.sv =====
// Top level of the binary to decimal ASCII converter.
// An item is taken when start is high and busy is low; busy then stays high until the item is done.
// A new item is accepted only after the last one is done: 32 conversion steps through the digit
// cell chain, then 10 digit emission steps, then a return to idle.
// A minus sign is strobed, from a register, after the first conversion step, the digits during emission.
// Synchronous reset clears the controller and the strobe; the receiver cannot stall.
module binary_to_decimal_ascii (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  output logic        busy,
  input  logic [31:0] value,
  input  logic        signed_mode,
  output logic [7:0]  character,
  output logic        last,
  output logic        strobe
);
  import b2da_pkg::*;

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_CONV = 2'd1;
  localparam logic [1:0] ST_EMIT = 2'd2;

  logic [1:0]        state;
  logic [1:0]        state_next;
  logic [CNT_W-1:0]  cnt;
  logic [CNT_W-1:0]  cnt_next;
  logic [WORD_W-1:0] sreg;
  logic              neg;
  logic              started;
  logic              accept;
  logic              show;
  cell_ctrl_t        ctrl;

  logic   [NUM_DIGITS:0] bits;
  digit_t                digits [NUM_DIGITS];
  digit_t                digit_ins [NUM_DIGITS];

  assign busy   = (state != ST_IDLE);
  assign accept = start && !busy;

  assign bits[0] = sreg[WORD_W-1];

  for (genvar i = 0; i < NUM_DIGITS; i++) begin : g_cell
    if (i == 0) begin : g_first
      assign digit_ins[i] = '0;
    end else begin : g_rest
      assign digit_ins[i] = digits[i-1];
    end
    b2da_cell u_cell (
      .clk      (clk),
      .ctrl     (ctrl),
      .bit_in   (bits[i]),
      .digit_in (digit_ins[i]),
      .bit_out  (bits[i+1]),
      .digit    (digits[i])
    );
  end

  assign show = started || (digits[NUM_DIGITS-1] != '0) ||
                (cnt == CNT_W'(NUM_DIGITS - 1));

  always_comb begin
    state_next       = state;
    cnt_next         = cnt;
    ctrl.clear       = accept;
    ctrl.shift_bit   = 1'b0;
    ctrl.shift_digit = 1'b0;
    case (state)
      ST_IDLE: begin
        if (accept) begin
          state_next = ST_CONV;
          cnt_next   = '0;
        end
      end
      ST_CONV: begin
        ctrl.shift_bit = 1'b1;
        cnt_next       = cnt + 1'b1;
        if (cnt == CNT_W'(WORD_W - 1)) begin
          state_next = ST_EMIT;
          cnt_next   = '0;
        end
      end
      ST_EMIT: begin
        ctrl.shift_digit = 1'b1;
        cnt_next         = cnt + 1'b1;
        if (cnt == CNT_W'(NUM_DIGITS - 1)) begin
          state_next = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state  <= ST_IDLE;
      cnt    <= '0;
      strobe <= 1'b0;
    end else begin
      state  <= state_next;
      cnt    <= cnt_next;
      strobe <= ((state == ST_CONV) && (cnt == '0) && neg) ||
                ((state == ST_EMIT) && show);
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      neg     <= signed_mode && value[WORD_W-1];
      sreg    <= (signed_mode && value[WORD_W-1]) ? (~value + 1'b1) : value;
      started <= 1'b0;
    end else if (state == ST_CONV) begin
      sreg <= {sreg[WORD_W-2:0], 1'b0};
    end else if (state == ST_EMIT && show) begin
      started <= 1'b1;
    end
    if (state == ST_CONV) begin
      character <= ASCII_MINUS;
      last      <= 1'b0;
    end else begin
      character <= ASCII_ZERO + {4'b0, digits[NUM_DIGITS-1]};
      last      <= (cnt == CNT_W'(NUM_DIGITS - 1));
    end
  end

endmodule

// ===== sv/b2da_checker.sv =====
// Port-level checks of the binary to decimal ASCII converter and their binding.
module b2da_assert (
  input logic       clk,
  input logic       rst,
  input logic       start,
  input logic       busy,
  input logic [7:0] character,
  input logic       last,
  input logic       strobe
);
  import b2da_pkg::*;

  a_accept_busy: assert property (@(posedge clk) disable iff (rst)
    start && !busy |=> busy)
    else $error("busy did not rise after an item was accepted");

  a_char_range: assert property (@(posedge clk) disable iff (rst)
    strobe |-> (character == ASCII_MINUS) ||
               ((character >= ASCII_ZERO) && (character <= ASCII_ZERO + 8'd9)))
    else $error("character is neither a sign nor a digit");

  a_sign_not_last: assert property (@(posedge clk) disable iff (rst)
    strobe && (character == ASCII_MINUS) |-> !last)
    else $error("a minus sign ended an item");

  a_quiet_after_last: assert property (@(posedge clk) disable iff (rst)
    strobe && last |=> !strobe)
    else $error("a result followed the last character of an item");

  a_reset_idle: assert property (@(posedge clk)
    rst |=> !strobe && !busy)
    else $error("block not idle after reset");

endmodule

bind binary_to_decimal_ascii b2da_assert u_b2da_assert (
  .clk       (clk),
  .rst       (rst),
  .start     (start),
  .busy      (busy),
  .character (character),
  .last      (last),
  .strobe    (strobe)
);
